[sv/plist_pkg.sv]
// Shared types and constants for the positional array list.
// Depends on nothing; used by the top level and the testbench.
`timescale 1ns / 1ps

package plist_pkg;

   // Storage geometry.
   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = 6;
   localparam int POS_W    = 6;
   localparam int VAL_W    = 32;
   localparam int OP_W     = 3;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_GET    = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

   // Result status codes.
   localparam logic STATUS_DONE   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]         operation;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                    status;
      logic [POS_W-1:0]        position_out;
      logic signed [VAL_W-1:0] value_out;
      logic [CNT_W-1:0]        count;
      logic                    empty_res;
   } rsp_type;

endpackage

[sv/positional_array_list_unit.sv]
// Top level of the positional array list: control sequencer around one entry RAM.
// Depends on plist_pkg and plist_ram.
`timescale 1ns / 1ps

// The block keeps an ordered list of up to 32 signed 32-bit values, addressed
// by 1-based position. Each request item on the req_ channel (valid/ready)
// carries an operation, a position and a value; exactly one result item leaves
// on the rsp_ channel (valid/ready) with status, position, value, count and an
// empty flag. Requests are taken one at a time: req_ready is high only while
// the sequencer is idle.
// All entries live in one RAM with one read and one write port and registered
// read data; every entry move is a read followed by a write-back, and find
// reads and compares one entry at a time.
// The result sits in an output register, so a new request is accepted while
// the previous result still waits; if the receiver stalls, the next result
// is held inside until the output register frees.
// Reset empties the list at once; entry contents are left as they are and are
// never read past the count.

module positional_array_list_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  plist_pkg::req_type  req_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output plist_pkg::rsp_type  rsp_item
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GET_RD,
      ST_GET_WAIT,
      ST_FIND_RD,
      ST_FIND_CMP,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_PUT,
      ST_DEL_RD,
      ST_DEL_GOT,
      ST_MV_RD,
      ST_MV_WR,
      ST_REPLY
   } state_type;

   state_type                          state_ff, state_in;
   logic [plist_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [plist_pkg::CNT_W-1:0]        idx_ff, idx_in;
   logic [plist_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [plist_pkg::VAL_W-1:0]        val_ff, val_in;
   logic                               res_status_ff, res_status_in;
   logic [plist_pkg::POS_W-1:0]        res_pos_ff, res_pos_in;
   logic [plist_pkg::VAL_W-1:0]        res_val_ff, res_val_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   plist_pkg::rsp_type                 rsp_item_ff, rsp_item_in;

   logic                               mem_wr_en;
   logic [plist_pkg::IDX_W-1:0]        mem_wr_addr;
   logic [plist_pkg::VAL_W-1:0]        mem_wr_data;
   logic                               mem_rd_en;
   logic [plist_pkg::IDX_W-1:0]        mem_rd_addr;
   logic [plist_pkg::VAL_W-1:0]        mem_rd_data;

   logic [plist_pkg::CNT_W-1:0]        idx_dec;
   logic [plist_pkg::CNT_W-1:0]        idx_inc;
   logic [plist_pkg::CNT_W-1:0]        pos_dec;
   logic [plist_pkg::CNT_W:0]          count_plus1;
   logic                               req_pos_bad;

   // Entry storage.
   plist_ram #(
      .WIDTH(plist_pkg::VAL_W),
      .DEPTH(plist_pkg::CAPACITY)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   assign idx_dec     = idx_ff - 1'b1;
   assign idx_inc     = idx_ff + 1'b1;
   assign pos_dec     = pos_ff - 1'b1;
   assign count_plus1 = {1'b0, count_ff} + 1'b1;
   // Position outside 1..count for get and delete.
   assign req_pos_bad = (req_item.position == '0) || (req_item.position > count_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Sequencer: next state, memory accesses and staged result.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_val_in    = res_val_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_item_in   = rsp_item_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff[plist_pkg::IDX_W-1:0];
      mem_wr_data   = mem_rd_data;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = idx_ff[plist_pkg::IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pos_in        = req_item.position;
               val_in        = req_item.value;
               res_status_in = plist_pkg::STATUS_REJECT;
               res_pos_in    = '0;
               res_val_in    = '0;
               state_in      = ST_REPLY;
               unique case (req_item.operation)
                  plist_pkg::OP_CLEAR: begin
                     count_in      = '0;
                     res_status_in = plist_pkg::STATUS_DONE;
                  end
                  plist_pkg::OP_GET: begin
                     if (!req_pos_bad) begin
                        state_in = ST_GET_RD;
                     end
                  end
                  plist_pkg::OP_FIND: begin
                     idx_in = '0;
                     if (count_ff != '0) begin
                        state_in = ST_FIND_RD;
                     end
                  end
                  plist_pkg::OP_INSERT: begin
                     idx_in = count_ff;
                     if ((count_ff != plist_pkg::CNT_W'(plist_pkg::CAPACITY)) &&
                         (req_item.position != '0) &&
                         ({1'b0, req_item.position} <= count_plus1)) begin
                        state_in = (count_ff >= req_item.position) ? ST_INS_RD : ST_INS_PUT;
                     end
                  end
                  plist_pkg::OP_DELETE: begin
                     if (!req_pos_bad) begin
                        state_in = ST_DEL_RD;
                     end
                  end
                  default: begin
                     state_in = ST_REPLY;
                  end
               endcase
            end
         end

         // Get: read the entry, then capture it.
         ST_GET_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = pos_dec[plist_pkg::IDX_W-1:0];
            state_in    = ST_GET_WAIT;
         end
         ST_GET_WAIT: begin
            res_status_in = plist_pkg::STATUS_DONE;
            res_pos_in    = pos_ff;
            res_val_in    = mem_rd_data;
            state_in      = ST_REPLY;
         end

         // Find: read one entry, compare, advance until a hit or the end.
         ST_FIND_RD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_FIND_CMP;
         end
         ST_FIND_CMP: begin
            if (mem_rd_data == val_ff) begin
               res_status_in = plist_pkg::STATUS_DONE;
               res_pos_in    = idx_inc;
               state_in      = ST_REPLY;
            end else if (idx_inc == count_ff) begin
               state_in = ST_REPLY;
            end else begin
               idx_in   = idx_inc;
               state_in = ST_FIND_RD;
            end
         end

         // Insert: move entries up from the tail, then place the new value.
         ST_INS_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_dec[plist_pkg::IDX_W-1:0];
            state_in    = ST_INS_WR;
         end
         ST_INS_WR: begin
            mem_wr_en = 1'b1;
            idx_in    = idx_dec;
            state_in  = (idx_ff == pos_ff) ? ST_INS_PUT : ST_INS_RD;
         end
         ST_INS_PUT: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = pos_dec[plist_pkg::IDX_W-1:0];
            mem_wr_data   = val_ff;
            count_in      = count_ff + 1'b1;
            res_status_in = plist_pkg::STATUS_DONE;
            res_pos_in    = pos_ff;
            state_in      = ST_REPLY;
         end

         // Delete: capture the removed entry, then move later entries down.
         ST_DEL_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = pos_dec[plist_pkg::IDX_W-1:0];
            state_in    = ST_DEL_GOT;
         end
         ST_DEL_GOT: begin
            res_status_in = plist_pkg::STATUS_DONE;
            res_pos_in    = pos_ff;
            res_val_in    = mem_rd_data;
            idx_in        = pos_ff;
            if (pos_ff == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_REPLY;
            end else begin
               state_in = ST_MV_RD;
            end
         end
         ST_MV_RD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_MV_WR;
         end
         ST_MV_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_dec[plist_pkg::IDX_W-1:0];
            idx_in      = idx_inc;
            if (idx_inc == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_REPLY;
            end else begin
               state_in = ST_MV_RD;
            end
         end

         // Hand the result to the output register once it is free.
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.status       = res_status_ff;
               rsp_item_in.position_out = res_pos_ff;
               rsp_item_in.value_out    = res_val_ff;
               rsp_item_in.count        = count_ff;
               rsp_item_in.empty_res    = (count_ff == '0);
               state_in                 = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, count, working registers and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_val_ff    <= res_val_in;
      rsp_item_ff   <= rsp_item_in;
   end

endmodule

[sv/plist_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module plist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for positional_array_list_unit.
// Depends on plist_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [plist_pkg::OP_W-1:0]         OP_TOP_CODE   = '1;
   localparam logic [plist_pkg::POS_W-1:0]        POS_TOP       = '1;
   localparam logic signed [plist_pkg::VAL_W-1:0] VAL_MAX       = 32'sh7FFF_FFFF;
   localparam logic signed [plist_pkg::VAL_W-1:0] VAL_MIN       = 32'sh8000_0000;
   localparam int                                 CYCLE_LIMIT   = 1_000_000;
   localparam int                                 SETTLE_CYCLES = 80;
   localparam int                                 MAX_GAP       = 40;
   localparam int                                 PHASE_ITEMS   = 375;
   localparam int                                 REPORT_LIMIT  = 10;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   plist_pkg::req_type req_item  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   plist_pkg::rsp_type rsp_item;

   // Reference copy of the list, advanced as each item is accepted.
   logic signed [plist_pkg::VAL_W-1:0] list_vals [plist_pkg::CAPACITY];
   int      list_len = 0;
   bit      grow_mode = 1'b1;

   plist_pkg::rsp_type pending_results [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      hold_left = 0;

   positional_array_list_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: a long hold-off when one is requested, otherwise random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare each accepted result item with the oldest predicted one.
   always @(posedge clock) begin
      plist_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("Unexpected result item at cycle %0d: %p", cycle_count, rsp_item);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.status !== want.status ||
                rsp_item.position_out !== want.position_out ||
                rsp_item.value_out !== want.value_out ||
                rsp_item.count !== want.count ||
                rsp_item.empty_res !== want.empty_res) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $write("Mismatch at cycle %0d: expected status %0d position %0d",
                         cycle_count, want.status, want.position_out);
                  $write(" value %0d count %0d empty %0d,",
                         want.value_out, want.count, want.empty_res);
                  $display(" got status %0d position %0d value %0d count %0d empty %0d",
                           rsp_item.status, rsp_item.position_out, rsp_item.value_out,
                           rsp_item.count, rsp_item.empty_res);
               end
            end
         end
      end
   end

   // Apply one operation to the reference list and return the result it should produce.
   function automatic plist_pkg::rsp_type apply_list_op(input plist_pkg::req_type item);
      plist_pkg::rsp_type res;
      int      pos;
      int      idx;
      res = '0;
      res.status = plist_pkg::STATUS_DONE;
      pos = int'(item.position);
      case (item.operation)
         plist_pkg::OP_CLEAR: begin
            list_len = 0;
         end
         plist_pkg::OP_GET: begin
            if (pos < 1 || pos > list_len) begin
               res.status = plist_pkg::STATUS_REJECT;
            end else begin
               res.position_out = item.position;
               res.value_out = list_vals[pos-1];
            end
         end
         plist_pkg::OP_FIND: begin
            idx = 0;
            while (idx < list_len && list_vals[idx] != item.value) idx++;
            if (idx < list_len) begin
               res.position_out = plist_pkg::POS_W'(idx + 1);
            end else begin
               res.status = plist_pkg::STATUS_REJECT;
            end
         end
         plist_pkg::OP_INSERT: begin
            if (list_len >= plist_pkg::CAPACITY || pos < 1 || pos > list_len + 1) begin
               res.status = plist_pkg::STATUS_REJECT;
            end else begin
               for (idx = list_len; idx >= pos; idx--) list_vals[idx] = list_vals[idx-1];
               list_vals[pos-1] = item.value;
               list_len++;
               res.position_out = item.position;
            end
         end
         plist_pkg::OP_DELETE: begin
            if (pos < 1 || pos > list_len) begin
               res.status = plist_pkg::STATUS_REJECT;
            end else begin
               res.value_out = list_vals[pos-1];
               for (idx = pos; idx < list_len; idx++) list_vals[idx-1] = list_vals[idx];
               list_len--;
               res.position_out = item.position;
            end
         end
         default: begin
            res.status = plist_pkg::STATUS_REJECT;
         end
      endcase
      res.count = plist_pkg::CNT_W'(list_len);
      res.empty_res = (list_len == 0);
      return res;
   endfunction

   function automatic plist_pkg::req_type make_item(input logic [plist_pkg::OP_W-1:0] op,
                                                    input int pos,
                                                    input logic signed [plist_pkg::VAL_W-1:0] val);
      plist_pkg::req_type item;
      item.operation = op;
      item.position = plist_pkg::POS_W'(pos);
      item.value = val;
      return item;
   endfunction

   // Values lean toward a small pool so that find hits and duplicates are common.
   function automatic logic signed [plist_pkg::VAL_W-1:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom_range(7);
         1: begin
            case ($urandom_range(3))
               0: return VAL_MAX;
               1: return VAL_MIN;
               2: return '0;
               default: return -1;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   // Mostly well-formed operations, drifting between filling and draining the list.
   function automatic plist_pkg::req_type gen_random_item();
      plist_pkg::req_type item;
      int      r;
      if (list_len == plist_pkg::CAPACITY) grow_mode = 1'b0;
      if (list_len == 0) grow_mode = 1'b1;
      if ($urandom_range(63) == 0) grow_mode = !grow_mode;
      item.value = pick_value();
      item.position = plist_pkg::POS_W'($urandom_range(int'(POS_TOP)));
      r = $urandom_range(99);
      if (r < 1) begin
         item.operation = plist_pkg::OP_CLEAR;
      end else if (r < 4) begin
         item.operation = plist_pkg::OP_W'($urandom_range(int'(plist_pkg::OP_DELETE) + 1,
                                                          int'(OP_TOP_CODE)));
      end else if (r < (grow_mode ? 50 : 22)) begin
         item.operation = plist_pkg::OP_INSERT;
      end else if (r < (grow_mode ? 62 : 52)) begin
         item.operation = plist_pkg::OP_DELETE;
      end else if (r < (grow_mode ? 80 : 75)) begin
         item.operation = plist_pkg::OP_GET;
      end else begin
         item.operation = plist_pkg::OP_FIND;
         if (list_len > 0 && $urandom_range(99) < 60) begin
            item.value = list_vals[$urandom_range(list_len - 1)];
         end
      end
      if ($urandom_range(99) < 85) begin
         if (item.operation == plist_pkg::OP_INSERT) begin
            item.position = plist_pkg::POS_W'($urandom_range(1, list_len + 1));
         end else if (list_len > 0) begin
            item.position = plist_pkg::POS_W'($urandom_range(1, list_len));
         end
      end
      return item;
   endfunction

   // Offer one item after a random idle gap and record its prediction once accepted.
   task automatic send_item(input plist_pkg::req_type item);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_list_op(item));
   endtask

   // Stop offering and wait until every predicted result has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Extremes of the fields and special cases, on a short list.
   task automatic test_directed_ops();
      int code;
      send_item(make_item(plist_pkg::OP_GET, 1, 0));
      send_item(make_item(plist_pkg::OP_DELETE, 1, 0));
      send_item(make_item(plist_pkg::OP_FIND, 0, 0));
      send_item(make_item(plist_pkg::OP_INSERT, 0, 5));
      send_item(make_item(plist_pkg::OP_INSERT, 2, 5));
      send_item(make_item(plist_pkg::OP_INSERT, 1, VAL_MAX));
      send_item(make_item(plist_pkg::OP_INSERT, 1, VAL_MIN));
      send_item(make_item(plist_pkg::OP_INSERT, 3, -1));
      send_item(make_item(plist_pkg::OP_INSERT, POS_TOP, 5));
      send_item(make_item(plist_pkg::OP_GET, 1, 0));
      send_item(make_item(plist_pkg::OP_GET, 3, 0));
      send_item(make_item(plist_pkg::OP_GET, 4, 0));
      send_item(make_item(plist_pkg::OP_GET, POS_TOP, 0));
      send_item(make_item(plist_pkg::OP_INSERT, 2, -1));
      send_item(make_item(plist_pkg::OP_FIND, 0, -1));
      send_item(make_item(plist_pkg::OP_FIND, 0, 12345));
      send_item(make_item(plist_pkg::OP_DELETE, 4, 0));
      send_item(make_item(plist_pkg::OP_DELETE, 0, 0));
      send_item(make_item(plist_pkg::OP_DELETE, 1, 0));
      for (code = int'(plist_pkg::OP_DELETE) + 1; code <= int'(OP_TOP_CODE); code++) begin
         send_item(make_item(plist_pkg::OP_W'(code), 1, -1));
      end
      send_item(make_item(plist_pkg::OP_CLEAR, POS_TOP, -1));
      send_item(make_item(plist_pkg::OP_GET, 1, 0));
      drain_results();
   endtask

   // Fill the list to capacity, then try to overflow it and work at both ends.
   task automatic test_full_list();
      send_item(make_item(plist_pkg::OP_CLEAR, 0, 0));
      repeat (plist_pkg::CAPACITY) begin
         send_item(make_item(plist_pkg::OP_INSERT, $urandom_range(1, list_len + 1),
                             pick_value()));
      end
      send_item(make_item(plist_pkg::OP_INSERT, 1, 7));
      send_item(make_item(plist_pkg::OP_INSERT, plist_pkg::CAPACITY + 1, 7));
      send_item(make_item(plist_pkg::OP_GET, plist_pkg::CAPACITY, 0));
      send_item(make_item(plist_pkg::OP_FIND, 0, list_vals[plist_pkg::CAPACITY-1]));
      send_item(make_item(plist_pkg::OP_DELETE, plist_pkg::CAPACITY, 0));
      send_item(make_item(plist_pkg::OP_DELETE, 1, 0));
      drain_results();
   endtask

   // Random traffic under one idling setting.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int num_items);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (num_items) send_item(gen_random_item());
      drain_results();
   endtask

   // Receiver holds off long enough for the block to fill and stall its input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 300;
      repeat (16) send_item(gen_random_item());
      drain_results();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_ops();
      test_full_list();
      test_random_traffic(0, 0, PHASE_ITEMS);
      test_random_traffic(77, 0, PHASE_ITEMS);
      test_backpressure();
      test_random_traffic(0, 77, PHASE_ITEMS);
      test_random_traffic(14, 14, PHASE_ITEMS);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
